[hw/rtl/mpq_pkg.sv]
package mpq_pkg;

	localparam int LEVELS      = 16;
	localparam int LEVEL_DEPTH = 16;
	localparam int ID_WIDTH    = 8;

	localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int PTR_W  = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
	localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
	localparam int TOT_W  = $clog2(LEVELS * LEVEL_DEPTH + 1);
	localparam int ACT_W  = $clog2(LEVELS + 1);
	localparam int ADDR_W = LVL_W + PTR_W;

	// port field widths
	localparam int ITEM_W   = 8;
	localparam int LEVEL_W  = 4;
	localparam int STATUS_W = 2;
	localparam int TOTAL_W  = 9;
	localparam int ACTIVE_W = 5;
	localparam int LCOUNT_W = 5;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_POP_EMPTY = 2'd1,
		ST_PUSH_FULL = 2'd2
	} status_t;

	typedef logic [LVL_W-1:0]    lvl_t;
	typedef logic [PTR_W-1:0]    ptr_t;
	typedef logic [CNT_W-1:0]    cnt_t;
	typedef logic [TOT_W-1:0]    tot_t;
	typedef logic [ACT_W-1:0]    act_t;
	typedef logic [ID_WIDTH-1:0] id_t;
	typedef logic [ADDR_W-1:0]   addr_t;

	typedef struct packed {
		logic found;
		lvl_t idx;
	} first_t;

	typedef struct packed {
		logic  we;
		addr_t waddr;
		id_t   wdata;
		logic  re;
		addr_t raddr;
	} mem_req_t;

	typedef struct packed {
		status_t status;
		logic    pop_ok;
		lvl_t    head_level;
		logic    empty;
		tot_t    total;
		act_t    active;
		cnt_t    lcount;
	} res_t;

	// priority encoder: lowest set bit wins
	function automatic first_t first_level(input logic [LEVELS-1:0] ne);
		first_t f;
		f = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (ne[l]) begin
				f.found = 1'b1;
				f.idx   = LVL_W'(l);
			end
		end
		return f;
	endfunction

	function automatic ptr_t ptr_inc(input ptr_t p);
		ptr_t r;
		r = (int'(p) == LEVEL_DEPTH - 1) ? '0 : p + 1'b1;
		return r;
	endfunction

endpackage

[hw/rtl/mpq_cmd_if.sv]
interface mpq_cmd_if;
	import mpq_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [ITEM_W-1:0]   item_id;
	logic [LEVEL_W-1:0]  level;

	modport source (output valid, command, item_id, level, input ready);
	modport sink (input valid, command, item_id, level, output ready);

endinterface

[hw/rtl/mpq_rsp_if.sv]
interface mpq_rsp_if;
	import mpq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ITEM_W-1:0]   popped_id;
	logic [ITEM_W-1:0]   head_id;
	logic [LEVEL_W-1:0]  head_level;
	logic                queue_empty;
	logic [TOTAL_W-1:0]  total_count;
	logic [ACTIVE_W-1:0] active_levels;
	logic [LCOUNT_W-1:0] level_count;

	modport source (
		output valid, status, popped_id, head_id, head_level, queue_empty,
			total_count, active_levels, level_count,
		input ready
	);
	modport sink (
		input valid, status, popped_id, head_id, head_level, queue_empty,
			total_count, active_levels, level_count,
		output ready
	);

endinterface

[hw/rtl/mpq_store.sv]
module mpq_store (
	input  logic              clk,
	input  mpq_pkg::mem_req_t req,
	output mpq_pkg::id_t      rdata
);
	import mpq_pkg::*;

	localparam int DEPTH = 2 ** ADDR_W;

	id_t mem [DEPTH];
	id_t rdata_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// write-first on a collision so a push into an empty head slot shows at once
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= (req.we && req.waddr == req.raddr) ? req.wdata : mem[req.raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[hw/rtl/mpq_ctrl.sv]
module mpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic              command,
	input  mpq_pkg::id_t      item_id,
	input  logic [3:0]        level,
	output mpq_pkg::mem_req_t mem_req,
	output mpq_pkg::res_t     res
);
	import mpq_pkg::*;

	cnt_t cnt_q [LEVELS];
	ptr_t rp_q  [LEVELS];
	ptr_t wp_q  [LEVELS];
	tot_t total_q;
	act_t active_q;

	cnt_t cnt_n [LEVELS];
	ptr_t rp_n  [LEVELS];
	ptr_t wp_n  [LEVELS];
	tot_t total_n;
	act_t active_n;

	logic [LEVELS-1:0] nonempty;
	logic [LEVELS-1:0] full;
	logic [LEVELS-1:0] ne_n;
	logic [LEVELS-1:0] grow;
	logic [LEVELS-1:0] shrink;
	first_t            head;
	first_t            head_n;
	lvl_t              li;
	logic              lvl_ok;
	logic              push_ok;
	logic              pop_ok;
	status_t           status;

	assign lvl_ok = int'(level) < LEVELS;
	assign li     = LVL_W'(level);

	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			nonempty[l] = cnt_q[l] != '0;
			full[l]     = int'(cnt_q[l]) >= LEVEL_DEPTH;
		end
	end

	assign head    = first_level(nonempty);
	assign push_ok = (command == CMD_PUSH) && lvl_ok && !full[li];
	assign pop_ok  = (command == CMD_POP) && head.found;

	always_comb begin
		status = ST_OK;
		if (command == CMD_POP && !head.found) begin
			status = ST_POP_EMPTY;
		end else if (command == CMD_PUSH && !push_ok) begin
			status = ST_PUSH_FULL;
		end
	end

	// per-level lanes
	always_comb begin
		for (int l = 0; l < LEVELS; l++) begin
			logic push_l;
			logic pop_l;
			push_l    = push_ok && (li == LVL_W'(l));
			pop_l     = pop_ok && (head.idx == LVL_W'(l));
			cnt_n[l]  = cnt_q[l];
			rp_n[l]   = rp_q[l];
			wp_n[l]   = wp_q[l];
			if (push_l) begin
				cnt_n[l] = cnt_q[l] + 1'b1;
				wp_n[l]  = ptr_inc(wp_q[l]);
			end else if (pop_l) begin
				cnt_n[l] = cnt_q[l] - 1'b1;
				rp_n[l]  = ptr_inc(rp_q[l]);
			end
			ne_n[l]   = cnt_n[l] != '0;
			grow[l]   = push_l && !nonempty[l];
			shrink[l] = pop_l && (cnt_q[l] == CNT_W'(1));
		end
	end

	always_comb begin
		total_n = total_q;
		if (push_ok) begin
			total_n = total_q + 1'b1;
		end else if (pop_ok) begin
			total_n = total_q - 1'b1;
		end
		active_n = active_q;
		if (|grow) begin
			active_n = active_q + 1'b1;
		end else if (|shrink) begin
			active_n = active_q - 1'b1;
		end
	end

	assign head_n = first_level(ne_n);

	always_comb begin
		mem_req.we    = fire && push_ok;
		mem_req.waddr = {li, wp_q[li]};
		mem_req.wdata = item_id;
		mem_req.re    = fire;
		mem_req.raddr = {head_n.idx, rp_n[head_n.idx]};
	end

	always_comb begin
		res.status     = status;
		res.pop_ok     = pop_ok;
		res.head_level = head_n.found ? head_n.idx : '0;
		res.empty      = !head_n.found;
		res.total      = total_n;
		res.active     = active_n;
		res.lcount     = lvl_ok ? cnt_n[li] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l] <= '0;
				rp_q[l]  <= '0;
				wp_q[l]  <= '0;
			end
			total_q  <= '0;
			active_q <= '0;
		end else if (fire) begin
			for (int l = 0; l < LEVELS; l++) begin
				cnt_q[l] <= cnt_n[l];
				rp_q[l]  <= rp_n[l];
				wp_q[l]  <= wp_n[l];
			end
			total_q  <= total_n;
			active_q <= active_n;
		end
	end

endmodule

[hw/rtl/multilevel_priority_fifo_queue.sv]
// Strict-priority queue with one FIFO of item ids per level (16 levels of 16 entries):
// a push appends an id to its level, a pop takes the oldest id of the lowest non-empty
// level, and each command gives one response word with status, popped id, new head and
// occupancy counts. A command word is taken into an input register and is executed once
// the output register is free or being read; its response is then held in the output
// register. While responses are taken, one command per cycle is sustained; this rests on
// the per-level counters and pointers updating together as a command executes and on the
// item store, whose one registered read port fetches the next head during each command.
module multilevel_priority_fifo_queue (
	input logic           clk,
	input logic           arst_n,
	mpq_cmd_if.sink       req,
	mpq_rsp_if.source     rsp
);
	import mpq_pkg::*;

	logic               s1_valid;
	logic               cmd_s1;
	logic [ITEM_W-1:0]  id_s1;
	logic [LEVEL_W-1:0] lvl_s1;

	logic                out_valid_q;
	status_t             status_q;
	logic [ITEM_W-1:0]   popped_q;
	logic [LEVEL_W-1:0]  head_level_q;
	logic                empty_q;
	logic [TOTAL_W-1:0]  total_q;
	logic [ACTIVE_W-1:0] active_q;
	logic [LCOUNT_W-1:0] lcount_q;

	logic     fire;
	logic     accept;
	mem_req_t mem_req;
	res_t     res;
	id_t      head_data;

	assign fire      = s1_valid && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid || fire;
	assign accept    = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (accept) begin
			s1_valid <= 1'b1;
		end else if (fire) begin
			s1_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= req.command;
			id_s1  <= req.item_id;
			lvl_s1 <= req.level;
		end
	end

	mpq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (fire),
		.command (cmd_s1),
		.item_id (ID_WIDTH'(id_s1)),
		.level   (lvl_s1),
		.mem_req (mem_req),
		.res     (res)
	);

	// read data holds the head of the queue as left by the last command
	mpq_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (head_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= res.status;
			popped_q     <= res.pop_ok ? ITEM_W'(head_data) : '0;
			head_level_q <= LEVEL_W'(res.head_level);
			empty_q      <= res.empty;
			total_q      <= TOTAL_W'(res.total);
			active_q     <= ACTIVE_W'(res.active);
			lcount_q     <= LCOUNT_W'(res.lcount);
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.status        = status_q;
	assign rsp.popped_id     = popped_q;
	assign rsp.head_id       = empty_q ? '0 : ITEM_W'(head_data);
	assign rsp.head_level    = head_level_q;
	assign rsp.queue_empty   = empty_q;
	assign rsp.total_count   = total_q;
	assign rsp.active_levels = active_q;
	assign rsp.level_count   = lcount_q;

endmodule

[hw/rtl/mpq_checker.sv]
module mpq_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [mpq_pkg::STATUS_W-1:0] status,
	input logic [mpq_pkg::ITEM_W-1:0]   popped_id,
	input logic [mpq_pkg::ITEM_W-1:0]   head_id,
	input logic [mpq_pkg::LEVEL_W-1:0]  head_level,
	input logic                         queue_empty,
	input logic [mpq_pkg::TOTAL_W-1:0]  total_count,
	input logic [mpq_pkg::ACTIVE_W-1:0] active_levels
);
	import mpq_pkg::*;

	// stalled response keeps valid, status, popped id, head id and total count
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(popped_id)
			&& $stable(head_id) && $stable(total_count))
		else $error("response word changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && queue_empty |-> total_count == '0 && active_levels == '0
			&& head_id == '0 && head_level == '0)
		else $error("empty queue reports contents");

	a_occupied: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !queue_empty |-> active_levels != '0
			&& TOTAL_W'(active_levels) <= total_count)
		else $error("occupied queue counts inconsistent");

	a_err_pop: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != ST_OK |-> popped_id == '0)
		else $error("error response carries a popped id");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_POP_EMPTY |-> queue_empty)
		else $error("pop on empty reported with items held");

endmodule

bind multilevel_priority_fifo_queue mpq_checker u_mpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.popped_id     (rsp.popped_id),
	.head_id       (rsp.head_id),
	.head_level    (rsp.head_level),
	.queue_empty   (rsp.queue_empty),
	.total_count   (rsp.total_count),
	.active_levels (rsp.active_levels)
);
